@@ src/csvt_pkg.sv @@
// shared types, codes and constants of the csv field row tokenizer
`default_nettype none

package csvt_pkg;

  // column limit and the saturation cap of the 8-bit column index
  localparam int MAX_COLUMNS = 256;
  localparam int COL_CAP_INT = ((MAX_COLUMNS - 1) > 255) ? 255 : (MAX_COLUMNS - 1);
  localparam logic [7:0] COL_CAP = 8'(COL_CAP_INT);

  // fixed characters
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;

  // register reset values
  localparam logic [7:0] DELIM_RESET = 8'd44;
  localparam logic [7:0] QUOTE_RESET = 8'd34;

  // register indexes
  localparam logic CFG_DELIMITER = 1'b0;
  localparam logic CFG_QUOTE     = 1'b1;

  // parse mode
  typedef enum logic [2:0] {
    MODE_START       = 3'd0,
    MODE_UNQUOTED    = 3'd1,
    MODE_QUOTED      = 3'd2,
    MODE_AFTER_QUOTE = 3'd3,
    MODE_AFTER_CR    = 3'd4
  } mode_t;

  // result kind
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_ROW   = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  // one result item without its last flag
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] col;
  } result_t;

  // everything the decoder says about one byte
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
    mode_t      mode_nxt;
    logic [7:0] col_nxt;
  } decode_t;

endpackage : csvt_pkg

`default_nettype wire

@@ src/csvt_decode.sv @@
// per-byte decode: results and next parse state from one byte and the current state
`default_nettype none

module csvt_decode (
  input  wire logic [7:0]       byte_value,
  input  wire logic             end_of_input,
  input  wire csvt_pkg::mode_t  mode,
  input  wire logic [7:0]       col,
  input  wire logic [7:0]       delim,
  input  wire logic [7:0]       quote,
  output csvt_pkg::decode_t     dec
);
  import csvt_pkg::*;

  mode_t      eff_mode;
  logic       is_lf;
  logic       is_cr;
  logic       is_dl;
  logic       is_q;
  logic [7:0] col_inc;

  // byte classes and saturating column step
  assign is_lf   = (byte_value == CH_LF);
  assign is_cr   = (byte_value == CH_CR);
  assign is_dl   = (byte_value == delim);
  assign is_q    = (byte_value == quote);
  assign col_inc = (col < COL_CAP) ? col + 8'd1 : col;
  assign eff_mode = (mode == MODE_AFTER_CR) ? MODE_START : mode;

  always_comb begin
    dec.count    = 2'd0;
    dec.res0     = '{kind: KIND_DATA, data: byte_value, col: col};
    dec.res1     = '{kind: KIND_ROW, data: 8'd0, col: col};
    dec.mode_nxt = eff_mode;
    dec.col_nxt  = col;

    if (mode == MODE_AFTER_CR && is_lf) begin
      // lf of a crlf pair is swallowed
      dec.mode_nxt = MODE_START;
    end else if (eff_mode == MODE_QUOTED) begin
      if (is_q) begin
        if (end_of_input) begin
          dec.count = 2'd1;
          dec.res0  = '{kind: KIND_ROW, data: 8'd0, col: col};
        end else begin
          dec.mode_nxt = MODE_AFTER_QUOTE;
        end
      end else begin
        dec.count    = end_of_input ? 2'd2 : 2'd1;
        dec.res1     = '{kind: KIND_ERROR, data: 8'd0, col: col};
      end
    end else if (eff_mode == MODE_START && is_q) begin
      // opening quote, error if the file ends here
      dec.mode_nxt = MODE_QUOTED;
      if (end_of_input) begin
        dec.count = 2'd1;
        dec.res0  = '{kind: KIND_ERROR, data: 8'd0, col: col};
      end
    end else if (is_lf || is_cr) begin
      // row end
      dec.count    = 2'd1;
      dec.res0     = '{kind: KIND_ROW, data: 8'd0, col: col};
      dec.col_nxt  = 8'd0;
      dec.mode_nxt = (is_cr && !is_lf) ? MODE_AFTER_CR : MODE_START;
    end else if (is_dl) begin
      // field end, plus a row end at end of input
      dec.count    = end_of_input ? 2'd2 : 2'd1;
      dec.res0     = '{kind: KIND_FIELD, data: 8'd0, col: col};
      dec.res1     = '{kind: KIND_ROW, data: 8'd0, col: col_inc};
      dec.col_nxt  = col_inc;
      dec.mode_nxt = MODE_START;
    end else if (eff_mode == MODE_AFTER_QUOTE) begin
      // skipped byte after a closing quote
      if (end_of_input) begin
        dec.count = 2'd1;
        dec.res0  = '{kind: KIND_ROW, data: 8'd0, col: col};
      end
    end else begin
      // plain data byte, field start or unquoted
      dec.count    = end_of_input ? 2'd2 : 2'd1;
      dec.mode_nxt = MODE_UNQUOTED;
    end

    // end of input restarts the parser
    if (end_of_input) begin
      dec.mode_nxt = MODE_START;
      dec.col_nxt  = 8'd0;
    end
  end

endmodule : csvt_decode

`default_nettype wire

@@ src/csv_field_row_tokenizer_core.sv @@
// top level of the csv field row tokenizer: input register, parse state, result register
//
// Usage
//   in_*  : one text byte per beat, in_tlast marks the last byte of a file.
//   out_* : result beats (data byte, end of field, end of row, error);
//           out_tlast marks the final result caused by one input byte.
//   cfg_* : delimiter (index 0) and quote byte (index 1), written while idle.
// Timing
//   a byte is registered on acceptance and decoded in the next cycle; its first
//   result is loaded into the result register once that is free. one byte per
//   cycle is sustained while out_tready is high; a byte with two results holds
//   the input register until its second result loads, since the single result
//   register takes one result per cycle. a byte with no result never waits.
// Reset
//   rst_n is synchronous, active low; the parser returns to field start,
//   column zero, delimiter ',' and quote '"'. no clearing pass is needed.
// Stall
//   while out_tready is low the result is held; the input register still
//   accepts a byte that causes no result, and otherwise fills and then
//   drops in_tready until the result beat moves.
`default_nettype none

module csv_field_row_tokenizer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_value
  input  wire logic        in_tlast,   // end_of_input
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] data_byte, [15:8] column_index
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast,  // last_of_run
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata
);
  import csvt_pkg::*;

  logic             in_valid_r;
  logic [7:0]       in_byte_r;
  logic             in_last_r;
  mode_t            mode_r;
  mode_t            mode_nxt;
  logic [7:0]       col_r;
  logic [7:0]       col_nxt;
  logic [7:0]       delim_r;
  logic [7:0]       quote_r;
  logic             sub_r;
  logic             sub_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  result_t          out_res_r;
  logic             out_last_r;
  decode_t          dec;
  logic             out_free;
  logic             load_first;
  logic             load_second;
  logic             consume;

  // byte decode against the current state
  csvt_decode u_decode (
    .byte_value   (in_byte_r),
    .end_of_input (in_last_r),
    .mode         (mode_r),
    .col          (col_r),
    .delim        (delim_r),
    .quote        (quote_r),
    .dec          (dec)
  );

  // result sequencing: first result, then the second if there is one
  assign out_free    = !out_valid_r || out_tready;
  assign load_first  = in_valid_r && !sub_r && (dec.count != 2'd0) && out_free;
  assign load_second = in_valid_r && sub_r && out_free;
  assign consume     = in_valid_r &&
                       ((dec.count == 2'd0) || (load_first && dec.count == 2'd1) ||
                        load_second);
  assign in_tready   = !in_valid_r || consume;

  always_comb begin
    sub_nxt       = sub_r;
    out_valid_nxt = out_valid_r;
    mode_nxt      = mode_r;
    col_nxt       = col_r;
    if (out_free) begin
      out_valid_nxt = load_first || load_second;
    end
    if (load_first && dec.count == 2'd2) begin
      sub_nxt = 1'b1;
    end else if (load_second) begin
      sub_nxt = 1'b0;
    end
    if (consume) begin
      mode_nxt = dec.mode_nxt;
      col_nxt  = dec.col_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      mode_r      <= MODE_START;
      col_r       <= 8'd0;
      sub_r       <= 1'b0;
      out_valid_r <= 1'b0;
      delim_r     <= DELIM_RESET;
      quote_r     <= QUOTE_RESET;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      mode_r      <= mode_nxt;
      col_r       <= col_nxt;
      sub_r       <= sub_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DELIMITER: delim_r <= cfg_wdata;
          CFG_QUOTE:     quote_r <= cfg_wdata;
          default:       delim_r <= delim_r;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (load_first) begin
      out_res_r  <= dec.res0;
      out_last_r <= (dec.count == 2'd1);
    end else if (load_second) begin
      out_res_r  <= dec.res1;
      out_last_r <= 1'b1;
    end
  end

  // result port, data byte zeroed for marks
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.col,
                       (out_res_r.kind == KIND_DATA) ? out_res_r.data : 8'd0};
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_last_r;

  // second phase only while a byte is held
  a_sub_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    sub_r |-> in_valid_r)
    else $error("second result phase without a held byte");

  // in the second phase the register holds the first, non-final result
  a_sub_first_held: assert property (@(posedge clk) disable iff (!rst_n)
    sub_r |-> (out_valid_r && !out_last_r))
    else $error("second phase without first result pending");

  // end of input restarts the parser
  a_eoi_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && in_last_r) |=> (mode_r == MODE_START && col_r == 8'd0))
    else $error("parser not restarted after end of input");

  // a row end resets the column
  a_after_cr_col: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_AFTER_CR) |-> (col_r == 8'd0))
    else $error("column not cleared after carriage return");

endmodule : csv_field_row_tokenizer_core

`default_nettype wire

@@ dv/csv_token_checker.sv @@
// result checker for the csv tokenizer: tracks the byte and result streams and compares beats
`timescale 1ns / 1ps

module csv_token_checker (
  input  logic        clk,
  input  logic        rst_n,
  // byte stream
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tlast,   // end_of_input
  // result stream
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [7:0] data_byte, [15:8] column_index
  input  logic [1:0]  out_tuser,  // [1:0] kind
  input  logic        out_tlast,  // last_of_run
  // register writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  // status toward the testbench top
  output int          error_count,
  output int          pending,
  output int          bytes_seen,
  output int          beats_checked
);
  import csvt_pkg::*;

  // one expected result beat
  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] col;
    logic       last;
  } token_t;

  token_t     token_q[$];

  // shadow of the parser state and registers
  logic [7:0] delim_reg;
  logic [7:0] quote_reg;
  mode_t      parse_st;
  logic [7:0] col_cnt;
  int         run_len;

  task automatic report_mismatch(input string msg);
    if (error_count < 100) $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic restart_parse();
    parse_st = MODE_START;
    col_cnt  = 8'd0;
  endtask

  task automatic emit_token(input kind_t k, input logic [7:0] d);
    token_t t;
    t.kind = k;
    t.data = d;
    t.col  = col_cnt;
    t.last = 1'b0;
    token_q.insert(token_q.size(), t);
    run_len++;
  endtask

  task automatic close_row(input mode_t next_mode);
    emit_token(KIND_ROW, 8'd0);
    restart_parse();
    parse_st = next_mode;
  endtask

  task automatic close_field(input logic eoi);
    emit_token(KIND_FIELD, 8'd0);
    if (col_cnt < COL_CAP) col_cnt++;
    parse_st = MODE_START;
    if (eoi) close_row(MODE_START);
  endtask

  // row and field terminators outside quotes: lf first, then cr, then the delimiter
  task automatic take_terminator(input logic [7:0] b, input logic eoi, output logic hit);
    hit = 1'b1;
    if (b == CH_LF) close_row(MODE_START);
    else if (b == CH_CR) close_row(eoi ? MODE_START : MODE_AFTER_CR);
    else if (b == delim_reg) close_field(eoi);
    else hit = 1'b0;
  endtask

  // expected results of one accepted byte
  task automatic tokenize_byte(input logic [7:0] b, input logic eoi);
    mode_t  m;
    logic   hit;
    token_t t;
    run_len = 0;
    m = parse_st;
    // lf right after cr is swallowed
    if (m == MODE_AFTER_CR) begin
      parse_st = MODE_START;
      m = MODE_START;
      if (b == CH_LF) begin
        if (eoi) restart_parse();
        return;
      end
    end
    case (m)
      MODE_QUOTED: begin
        if (b == quote_reg) begin
          if (eoi) close_row(MODE_START);
          else parse_st = MODE_AFTER_QUOTE;
        end else begin
          emit_token(KIND_DATA, b);
          // file ends inside quotes
          if (eoi) begin
            emit_token(KIND_ERROR, 8'd0);
            restart_parse();
          end
        end
      end
      MODE_UNQUOTED, MODE_AFTER_QUOTE: begin
        take_terminator(b, eoi, hit);
        if (!hit) begin
          // bytes after a closing quote are dropped
          if (m == MODE_UNQUOTED) emit_token(KIND_DATA, b);
          if (eoi) close_row(MODE_START);
        end
      end
      default: begin
        // field start: the quote byte wins over terminators
        if (b == quote_reg) begin
          parse_st = MODE_QUOTED;
          if (eoi) begin
            emit_token(KIND_ERROR, 8'd0);
            restart_parse();
          end
        end else begin
          take_terminator(b, eoi, hit);
          if (!hit) begin
            parse_st = MODE_UNQUOTED;
            emit_token(KIND_DATA, b);
            if (eoi) close_row(MODE_START);
          end
        end
      end
    endcase
    if (eoi) restart_parse();
    // flag the final result of this byte
    if (run_len > 0) begin
      t = token_q.pop_back();
      t.last = 1'b1;
      token_q.insert(token_q.size(), t);
    end
  endtask

  // watch both channels at each edge
  always @(posedge clk) begin : watch
    token_t want;
    if (!rst_n) begin
      delim_reg = DELIM_RESET;
      quote_reg = QUOTE_RESET;
      restart_parse();
      token_q.delete();
      error_count   = 0;
      bytes_seen    = 0;
      beats_checked = 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_DELIMITER) delim_reg = cfg_wdata;
        else quote_reg = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        bytes_seen++;
        tokenize_byte(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        beats_checked++;
        if (token_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected: kind %0d data %02h col %0d",
                                    out_tuser, out_tdata[7:0], out_tdata[15:8]));
        end else begin
          want = token_q.pop_front();
          if (out_tuser !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %s", out_tuser, want.kind.name()));
          if (out_tdata[7:0] !== want.data)
            report_mismatch($sformatf("data byte %02h, expected %02h", out_tdata[7:0], want.data));
          if (out_tdata[15:8] !== want.col)
            report_mismatch($sformatf("column %0d, expected %0d", out_tdata[15:8], want.col));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("last flag %b, expected %b", out_tlast, want.last));
        end
      end
      pending <= token_q.size();
    end
  end

endmodule

@@ dv/tb_csv_field_row_tokenizer_core.sv @@
// testbench top for the csv tokenizer: clock, reset, byte stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module tb_csv_field_row_tokenizer_core;
  import csvt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;   // [7:0] byte_value
  logic        in_tlast = 1'b0;   // end_of_input
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [15:0] out_tdata;         // [7:0] data_byte, [15:8] column_index
  logic [1:0]  out_tuser;         // [1:0] kind
  logic        out_tlast;         // last_of_run
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_DELIMITER;
  logic [7:0]  cfg_wdata = 8'd0;

  int errors;
  int pending;
  int bytes_seen;
  int beats_checked;
  int cycle_cnt = 0;
  int send_idle = 0;
  int stall_pct = 0;

  // text bytes waiting to be sent
  typedef struct {
    logic [7:0] b;
    logic       eoi;
  } text_beat_t;

  text_beat_t text_q[$];
  logic [7:0] delim_cur = DELIM_RESET;
  logic [7:0] quote_cur = QUOTE_RESET;

  csv_field_row_tokenizer_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  csv_token_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .error_count   (errors),
    .pending       (pending),
    .bytes_seen    (bytes_seen),
    .beats_checked (beats_checked)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic eoi);
    text_beat_t t;
    t.b = b;
    t.eoi = eoi;
    text_q.insert(text_q.size(), t);
  endtask

  // any byte that is no delimiter, quote or row end under the current setting
  function automatic logic [7:0] plain_byte();
    logic [7:0] v;
    do v = 8'($urandom_range(255));
    while (v == delim_cur || v == quote_cur || v == CH_LF || v == CH_CR);
    return v;
  endfunction

  // one field: mostly plain or quoted, sometimes raw noise
  task automatic add_field();
    int pick;
    int len;
    logic [7:0] v;
    pick = $urandom_range(9);
    len = $urandom_range(4);
    if (pick < 5) begin
      for (int i = 0; i < len; i++)
        push_byte((i > 0 && $urandom_range(9) == 0) ? quote_cur : plain_byte(), 1'b0);
    end else if (pick < 9) begin
      push_byte(quote_cur, 1'b0);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(9))
          7:       v = delim_cur;
          8:       v = CH_LF;
          9:       v = CH_CR;
          default: v = plain_byte();
        endcase
        if (v == quote_cur) v = plain_byte();
        push_byte(v, 1'b0);
      end
      push_byte(quote_cur, 1'b0);
      // stray bytes after the closing quote
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(2, 1)) push_byte(plain_byte(), 1'b0);
    end else begin
      repeat (len + 1) push_byte(8'($urandom_range(255)), 1'b0);
    end
  endtask

  // one small file of rows; some are cut short at a random byte
  task automatic build_file();
    int rows;
    int fields;
    int start;
    int cut;
    text_beat_t t;
    start = text_q.size();
    rows = $urandom_range(3, 1);
    for (int r = 0; r < rows; r++) begin
      fields = $urandom_range(4, 1);
      for (int f = 0; f < fields; f++) begin
        add_field();
        if (f < fields - 1) push_byte(delim_cur, 1'b0);
      end
      case ($urandom_range(3))
        0: push_byte(CH_LF, 1'b0);
        1: push_byte(CH_CR, 1'b0);
        2: begin
          push_byte(CH_CR, 1'b0);
          push_byte(CH_LF, 1'b0);
        end
        default: if (r < rows - 1) push_byte(CH_LF, 1'b0);
      endcase
    end
    if (text_q.size() == start) push_byte(plain_byte(), 1'b0);
    if ($urandom_range(4) == 0 && text_q.size() > start + 1) begin
      cut = $urandom_range(text_q.size() - 1, start + 1);
      while (text_q.size() > cut) void'(text_q.pop_back());
    end
    // end of file mark on the last byte
    t = text_q.pop_back();
    t.eoi = 1'b1;
    text_q.insert(text_q.size(), t);
  endtask

  task automatic fill_random(input int n_items);
    int goal;
    goal = text_q.size() + n_items;
    while (text_q.size() < goal) begin
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(5, 1))
          push_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
      else
        build_file();
    end
  endtask

  // send queued bytes, one beat per handshake
  task automatic play_text();
    text_beat_t t;
    while (text_q.size() > 0) begin
      t = text_q.pop_front();
      while ($urandom_range(99) < send_idle) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= t.b;
      in_tlast  <= t.eoi;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
    end
    in_tvalid <= 1'b0;
  endtask

  // wait for every result, then for bytes with no result to clear the pipe
  task automatic settle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] dlm, input logic [7:0] quo);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DELIMITER;
    cfg_wdata <= dlm;
    @(posedge clk);
    cfg_index <= CFG_QUOTE;
    cfg_wdata <= quo;
    @(posedge clk);
    cfg_we <= 1'b0;
    delim_cur = dlm;
    quote_cur = quo;
  endtask

  task automatic run_phase(input logic [7:0] dlm, input logic [7:0] quo, input int s_idle,
                           input int r_stall, input int n_items, input bit wide_row);
    settle();
    write_regs(dlm, quo);
    send_idle = s_idle;
    stall_pct = r_stall;
    // a row with more fields than the column index can count
    if (wide_row) begin
      repeat (258) push_byte(delim_cur, 1'b0);
      push_byte(CH_LF, 1'b0);
    end
    fill_random(n_items);
    play_text();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed bytes under the reset setting
    push_byte(8'h00, 1'b0);
    push_byte(DELIM_RESET, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(CH_LF, 1'b0);
    push_byte(CH_LF, 1'b0);          // empty line
    push_byte("a", 1'b0);
    push_byte(QUOTE_RESET, 1'b0);    // quote inside an unquoted field
    push_byte(CH_CR, 1'b0);
    push_byte(CH_LF, 1'b0);          // lf after cr
    push_byte(QUOTE_RESET, 1'b0);
    push_byte(DELIM_RESET, 1'b0);    // delimiter inside quotes
    push_byte(QUOTE_RESET, 1'b0);
    push_byte("z", 1'b0);            // skipped after closing quote
    push_byte(QUOTE_RESET, 1'b0);    // doubled quote, also skipped
    push_byte(CH_CR, 1'b0);
    push_byte("k", 1'b0);            // cr not followed by lf
    push_byte(DELIM_RESET, 1'b0);
    push_byte(DELIM_RESET, 1'b1);    // trailing delimiter at end of file
    push_byte(QUOTE_RESET, 1'b1);    // opening quote as the last byte
    push_byte(QUOTE_RESET, 1'b0);
    push_byte("w", 1'b1);            // file ends inside quotes
    push_byte("m", 1'b1);            // field closed by end of file
    push_byte(QUOTE_RESET, 1'b0);
    push_byte(QUOTE_RESET, 1'b1);    // closing quote at end of file
    push_byte(CH_CR, 1'b0);
    push_byte(CH_LF, 1'b1);          // crlf ending the file
    play_text();

    // random files under several settings and idle profiles
    run_phase(DELIM_RESET, QUOTE_RESET, 0, 0, 30, 1'b1);
    run_phase(8'd59, 8'd39, 85, 0, 60, 1'b0);
    run_phase(8'hFF, 8'h00, 0, 85, 60, 1'b0);
    run_phase(8'h00, 8'hFF, 8, 8, 60, 1'b0);
    run_phase(CH_CR, CH_LF, 0, 0, 30, 1'b0);
    run_phase(DELIM_RESET, DELIM_RESET, 0, 0, 30, 1'b0);
    settle();

    $display("run covered %0d text bytes and %0d result beats over six register settings,",
             bytes_seen, beats_checked);
    $display("with no idling, sender idle, receiver stall and light idling on both sides");
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
